/* rtl/cab_pkg.sv */
// Shared types and constants for the compressed sparse row table builder.
// Used by cab_core and csr_adjacency_builder_unit; no other dependencies.
package cab_pkg;

  localparam int MAX_ROWS    = 1024;
  localparam int MAX_ENTRIES = 4096;
  localparam int ROW_W       = 10;   // row index
  localparam int RIDX_W      = 11;   // row count / offset index, holds MAX_ROWS
  localparam int ENT_AW      = 12;   // entry store address
  localparam int CNT_W       = 13;   // counts, offsets, slots, holds MAX_ENTRIES
  localparam int SUM_W       = 23;   // sum of all counts
  localparam int VAL_W       = 32;
  localparam int CFG_W       = 11;

  // Request codes
  localparam logic [2:0] REQ_COUNT  = 3'd0;
  localparam logic [2:0] REQ_BUILD  = 3'd1;
  localparam logic [2:0] REQ_ADD    = 3'd2;
  localparam logic [2:0] REQ_FIN    = 3'd3;
  localparam logic [2:0] REQ_FIN_DD = 3'd4;
  localparam logic [2:0] REQ_RD_OFF = 3'd5;
  localparam logic [2:0] REQ_RD_VAL = 3'd6;

  // Status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_RANGE  = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_UNFIN  = 3'd3;
  localparam logic [2:0] ST_CAP    = 3'd4;
  localparam logic [2:0] ST_PHASE  = 3'd5;

  typedef enum logic [1:0] {PH_CNT, PH_ADD, PH_DONE} phase_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_CNT_WR,
    S_BLD_RD, S_BLD_AC, S_BLD_END, S_ADD_WR,
    S_FIN_TOT, S_FIN_RD, S_FIN_CK,
    S_DD_ROW, S_DD_E, S_SO_OUT, S_SO_V, S_SO_IN, S_SO_CMP,
    S_CP_RD, S_CP_WR, S_CP_END, S_DD_FIN,
    S_RD_OFF, S_RD_VAL, S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [ROW_W-1:0] row;
    logic [VAL_W-1:0] value;
    logic [ENT_AW-1:0] addr;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [VAL_W-1:0] data;
  } res_t;

endpackage

/* rtl/cab_core.sv */
// Sequencer and memories of the table builder: counts, offsets and entries.
// Depends on cab_pkg. One request at a time, result held until taken.
module cab_core
  import cab_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] row_count,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req_in,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res_out
);

  // Memories
  logic [CNT_W-1:0] cnt_mem [MAX_ROWS];
  logic [CNT_W-1:0] off_mem [MAX_ROWS+1];
  logic [VAL_W-1:0] ent_mem [MAX_ENTRIES];

  logic [ROW_W-1:0]  cnt_raddr, cnt_waddr;
  logic [CNT_W-1:0]  cnt_rdata, cnt_wdata;
  logic              cnt_we;
  logic [RIDX_W-1:0] off_raddr, off_waddr;
  logic [CNT_W-1:0]  off_rdata, off_wdata;
  logic              off_we;
  logic [ENT_AW-1:0] ent_raddr, ent_waddr;
  logic [VAL_W-1:0]  ent_rdata, ent_wdata;
  logic              ent_we;

  // Sequencer registers
  state_t            state, state_next;
  phase_t            phase, phase_next;
  logic [RIDX_W-1:0] built, built_next;
  req_t              req, req_next;
  logic [RIDX_W-1:0] idx, idx_next;
  logic [SUM_W-1:0]  sum, sum_next;
  logic [CNT_W-1:0]  s, s_next, e, e_next, w, w_next, start, start_next;
  logic [CNT_W-1:0]  ii, ii_next, j, j_next, slot;
  logic [VAL_W-1:0]  v, v_next, prev, prev_next;
  res_t              res, res_next;
  logic [RIDX_W-1:0] eff;

  // Clamp the configured row count to 1..MAX_ROWS
  always_comb begin
    if (row_count == '0) eff = RIDX_W'(1);
    else if (row_count > CFG_W'(MAX_ROWS)) eff = RIDX_W'(MAX_ROWS);
    else eff = row_count[RIDX_W-1:0];
  end

  assign slot      = off_rdata - cnt_rdata;
  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res_out   = res;

  // Memory ports: one write and one registered read each
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rdata <= cnt_mem[cnt_raddr];
    if (off_we) off_mem[off_waddr] <= off_wdata;
    off_rdata <= off_mem[off_raddr];
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_rdata <= ent_mem[ent_raddr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (idx == RIDX_W'(MAX_ROWS - 1)) state_next = S_IDLE;
      S_IDLE:    if (req_valid) state_next = S_DISP;
      S_DISP: begin
        unique case (req.req_type)
          REQ_COUNT:
            state_next = (phase != PH_CNT || {1'b0, req.row} >= eff) ? S_DONE : S_CNT_WR;
          REQ_BUILD:  state_next = (phase != PH_CNT) ? S_DONE : S_BLD_RD;
          REQ_ADD:
            state_next = (phase != PH_ADD || {1'b0, req.row} >= built) ? S_DONE : S_ADD_WR;
          REQ_FIN, REQ_FIN_DD: state_next = (phase != PH_ADD) ? S_DONE : S_FIN_TOT;
          REQ_RD_OFF:
            state_next = ({1'b0, req.addr} > CNT_W'(MAX_ROWS)) ? S_DONE : S_RD_OFF;
          REQ_RD_VAL:
            state_next = ({1'b0, req.addr} >= CNT_W'(MAX_ENTRIES)) ? S_DONE : S_RD_VAL;
          default:    state_next = S_DONE;
        endcase
      end
      S_CNT_WR:  state_next = S_DONE;
      S_BLD_RD:  state_next = S_BLD_AC;
      S_BLD_AC:  state_next = (idx + RIDX_W'(1) == eff) ? S_BLD_END : S_BLD_RD;
      S_BLD_END: state_next = S_DONE;
      S_ADD_WR:  state_next = S_DONE;
      S_FIN_TOT: state_next = S_FIN_RD;
      S_FIN_RD:  state_next = S_FIN_CK;
      S_FIN_CK: begin
        if (cnt_rdata != '0) state_next = S_DONE;
        else if (idx + RIDX_W'(1) == built)
          state_next = (req.req_type == REQ_FIN_DD) ? S_DD_ROW : S_DONE;
        else state_next = S_FIN_RD;
      end
      S_DD_ROW:  state_next = S_DD_E;
      S_DD_E:    state_next = S_SO_OUT;
      S_SO_OUT:  state_next = (ii >= e) ? S_CP_RD : S_SO_V;
      S_SO_V:    state_next = S_SO_IN;
      S_SO_IN:   state_next = (j > s) ? S_SO_CMP : S_SO_OUT;
      S_SO_CMP:  state_next = (ent_rdata > v) ? S_SO_IN : S_SO_OUT;
      S_CP_RD:   state_next = (j >= e) ? S_CP_END : S_CP_WR;
      S_CP_WR:   state_next = S_CP_RD;
      S_CP_END:  state_next = (idx + RIDX_W'(1) == built) ? S_DD_FIN : S_DD_ROW;
      S_DD_FIN:  state_next = S_DONE;
      S_RD_OFF:  state_next = S_DONE;
      S_RD_VAL:  state_next = S_DONE;
      S_DONE:    if (res_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    phase_next = phase;
    built_next = built;
    req_next   = req;
    idx_next   = idx;
    sum_next   = sum;
    s_next     = s;
    e_next     = e;
    w_next     = w;
    start_next = start;
    ii_next    = ii;
    j_next     = j;
    v_next     = v;
    prev_next  = prev;
    res_next   = res;
    cnt_raddr  = '0;
    cnt_we     = 1'b0;
    cnt_waddr  = '0;
    cnt_wdata  = '0;
    off_raddr  = '0;
    off_we     = 1'b0;
    off_waddr  = '0;
    off_wdata  = '0;
    ent_raddr  = '0;
    ent_we     = 1'b0;
    ent_waddr  = '0;
    ent_wdata  = '0;
    unique case (state)
      // Zero the count store after reset
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = idx[ROW_W-1:0];
        idx_next  = (idx == RIDX_W'(MAX_ROWS - 1)) ? '0 : idx + RIDX_W'(1);
      end
      S_IDLE: begin
        if (req_valid) begin
          req_next = req_in;
          res_next = '{status: ST_OK, data: '0};
          idx_next = '0;
        end
      end
      S_DISP: begin
        unique case (req.req_type)
          REQ_COUNT: begin
            if (phase != PH_CNT) res_next.status = ST_PHASE;
            else if ({1'b0, req.row} >= eff) res_next.status = ST_RANGE;
            else cnt_raddr = req.row;
          end
          REQ_BUILD: begin
            if (phase != PH_CNT) res_next.status = ST_PHASE;
            else begin
              off_we   = 1'b1;
              sum_next = '0;
            end
          end
          REQ_ADD: begin
            if (phase != PH_ADD) res_next.status = ST_PHASE;
            else if ({1'b0, req.row} >= built) res_next.status = ST_RANGE;
            else begin
              cnt_raddr = req.row;
              off_raddr = {1'b0, req.row} + RIDX_W'(1);
            end
          end
          REQ_FIN, REQ_FIN_DD: begin
            if (phase != PH_ADD) res_next.status = ST_PHASE;
            else off_raddr = built;
          end
          REQ_RD_OFF: begin
            if ({1'b0, req.addr} > CNT_W'(MAX_ROWS)) res_next.status = ST_RANGE;
            else off_raddr = req.addr[RIDX_W-1:0];
          end
          REQ_RD_VAL: begin
            if ({1'b0, req.addr} >= CNT_W'(MAX_ENTRIES)) res_next.status = ST_RANGE;
            else ent_raddr = req.addr;
          end
          default: res_next.status = ST_PHASE;
        endcase
      end
      // Increment the pending count unless saturated
      S_CNT_WR: begin
        if (cnt_rdata >= CNT_W'(MAX_ENTRIES)) res_next.status = ST_CAP;
        else begin
          cnt_we        = 1'b1;
          cnt_waddr     = req.row;
          cnt_wdata     = cnt_rdata + CNT_W'(1);
          res_next.data = VAL_W'(cnt_rdata + CNT_W'(1));
        end
      end
      // Prefix sum: read each row's count, then accumulate and write its offset
      S_BLD_RD: cnt_raddr = idx[ROW_W-1:0];
      S_BLD_AC: begin
        sum_next  = sum + SUM_W'(cnt_rdata);
        off_we    = 1'b1;
        off_waddr = idx + RIDX_W'(1);
        off_wdata = sum_next[CNT_W-1:0];
        idx_next  = idx + RIDX_W'(1);
      end
      S_BLD_END: begin
        res_next.data = VAL_W'(sum);
        if (sum > SUM_W'(MAX_ENTRIES)) res_next.status = ST_CAP;
        else begin
          phase_next = PH_ADD;
          built_next = eff;
        end
      end
      // Place a value at row end minus remaining count
      S_ADD_WR: begin
        if (cnt_rdata == '0) res_next.status = ST_FULL;
        else if (off_rdata < cnt_rdata) res_next.status = ST_CAP;
        else if (slot >= CNT_W'(MAX_ENTRIES)) res_next.status = ST_CAP;
        else begin
          ent_we        = 1'b1;
          ent_waddr     = slot[ENT_AW-1:0];
          ent_wdata     = req.value;
          cnt_we        = 1'b1;
          cnt_waddr     = req.row;
          cnt_wdata     = cnt_rdata - CNT_W'(1);
          res_next.data = VAL_W'(slot);
        end
      end
      S_FIN_TOT: begin
        res_next.data = VAL_W'(off_rdata);
        idx_next      = '0;
      end
      // Scan for any nonzero pending count
      S_FIN_RD: cnt_raddr = idx[ROW_W-1:0];
      S_FIN_CK: begin
        if (cnt_rdata != '0) res_next.status = ST_UNFIN;
        else if (idx + RIDX_W'(1) == built) begin
          if (req.req_type == REQ_FIN_DD) begin
            idx_next = '0;
            s_next   = '0;
            w_next   = '0;
          end else phase_next = PH_DONE;
        end else idx_next = idx + RIDX_W'(1);
      end
      // Dedup: fetch row end
      S_DD_ROW: off_raddr = idx + RIDX_W'(1);
      S_DD_E: begin
        e_next     = off_rdata;
        start_next = w;
        ii_next    = s + CNT_W'(1);
      end
      // Insertion sort of the row in place
      S_SO_OUT: begin
        if (ii < e) ent_raddr = ii[ENT_AW-1:0];
        else j_next = s;
      end
      S_SO_V: begin
        v_next = ent_rdata;
        j_next = ii;
      end
      S_SO_IN: begin
        if (j > s) ent_raddr = ENT_AW'(j - CNT_W'(1));
        else begin
          ent_we    = 1'b1;
          ent_waddr = j[ENT_AW-1:0];
          ent_wdata = v;
          ii_next   = ii + CNT_W'(1);
        end
      end
      S_SO_CMP: begin
        ent_we    = 1'b1;
        ent_waddr = j[ENT_AW-1:0];
        if (ent_rdata > v) begin
          ent_wdata = ent_rdata;
          j_next    = j - CNT_W'(1);
        end else begin
          ent_wdata = v;
          ii_next   = ii + CNT_W'(1);
        end
      end
      // Compact distinct values down to the write pointer
      S_CP_RD: if (j < e) ent_raddr = j[ENT_AW-1:0];
      S_CP_WR: begin
        if (j == s || ent_rdata != prev) begin
          ent_we    = 1'b1;
          ent_waddr = w[ENT_AW-1:0];
          ent_wdata = ent_rdata;
          w_next    = w + CNT_W'(1);
        end
        prev_next = ent_rdata;
        j_next    = j + CNT_W'(1);
      end
      S_CP_END: begin
        off_we    = 1'b1;
        off_waddr = idx;
        off_wdata = start;
        s_next    = e;
        idx_next  = idx + RIDX_W'(1);
      end
      S_DD_FIN: begin
        off_we        = 1'b1;
        off_waddr     = built;
        off_wdata     = w;
        res_next.data = VAL_W'(w);
        phase_next    = PH_DONE;
      end
      S_RD_OFF: res_next.data = VAL_W'(off_rdata);
      S_RD_VAL: res_next.data = ent_rdata;
      S_DONE:   ;
      default:  ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      phase <= PH_CNT;
      built <= RIDX_W'(MAX_ROWS);
      idx   <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      built <= built_next;
      idx   <= idx_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    req   <= req_next;
    sum   <= sum_next;
    s     <= s_next;
    e     <= e_next;
    w     <= w_next;
    start <= start_next;
    ii    <= ii_next;
    j     <= j_next;
    v     <= v_next;
    prev  <= prev_next;
    res   <= res_next;
  end

  // The table never returns to an earlier phase
  a_no_back_to_count: assert property (@(posedge clk) disable iff (rst)
    phase != PH_CNT |=> phase != PH_CNT) else $error("phase returned to counting");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |=> phase == PH_DONE) else $error("finished phase left");

  // Running total only grows during the prefix sum
  a_sum_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_BLD_AC |=> sum >= $past(sum)) else $error("prefix sum shrank");

  a_built_range: assert property (@(posedge clk) disable iff (rst)
    built != '0 && built <= RIDX_W'(MAX_ROWS)) else $error("built row count out of range");

endmodule

/* rtl/csr_adjacency_builder_unit.sv */
// Top level of the compressed sparse row table builder: handshakes,
// row_count register and result register. Depends on cab_pkg and cab_core.
//
// Usage: requests enter on in_valid/in_ready with req_type, row, value and
// addr; each request gives exactly one result on out_valid/out_ready with
// status and data. A transfer happens when valid and ready are both high.
// The row_count register is written with cfg_wr_en/cfg_wr_data; the user
// must do so only while idle, as the block itself does not enforce it.
// Flow: count requests per row, one build, one add per counted entry, then
// finish (or finish with dedup); reads of offsets and entries work any time.
// Count, add and reads pass through dispatch, one work state and the done
// state; a request refused at dispatch goes straight to done. Build reads
// and accumulates each row in use; finish scans the rows' pending counts
// until one is nonzero; dedup adds insertion sort and compaction per row.
// One request is in work at a time, set by the single sequencer on the
// count, offset and entry memories.
// After reset the count store is zeroed in one pass over every row, with
// in_ready low. A stalled receiver holds the result; one further result can
// wait inside the sequencer, after which in_ready stays low.
module csr_adjacency_builder_unit
  import cab_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        req_type,
  input  logic [ROW_W-1:0]  row,
  input  logic [VAL_W-1:0]  value,
  input  logic [ENT_AW-1:0] addr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [VAL_W-1:0]  data
);

  logic [CFG_W-1:0] row_count;
  req_t             req_in;
  res_t             res;
  logic             res_valid, res_ready;

  assign req_in    = '{req_type: req_type, row: row, value: value, addr: addr};
  assign res_ready = !out_valid || out_ready;

  // Hold the configured row count
  always_ff @(posedge clk) begin
    if (rst) row_count <= CFG_W'(MAX_ROWS);
    else if (cfg_wr_en) row_count <= cfg_wr_data;
  end

  cab_core u_core (
    .clk       (clk),
    .rst       (rst),
    .row_count (row_count),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req_in    (req_in),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_out   (res)
  );

  // Result register: load when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (res_valid && res_ready) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status <= res.status;
      data   <= res.data;
    end
  end

endmodule
